/* src/spba_pkg.sv */
`default_nettype none
package spba_pkg;

  localparam int MAX_PAGES_DEFAULT = 4096;

  localparam int REQ_W = 2;
  localparam int IDX_W = 12;
  localparam int ST_W  = 3;
  localparam int CNT_W = 13;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_OCCUPY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK           = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL         = 3'd1;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd2;
  localparam logic [ST_W-1:0] ST_ALREADY_OCC  = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE        = 3'd4;

  typedef enum logic [1:0] {
    RES_QUICK,
    RES_ALLOC,
    RES_LOOK
  } res_kind_e;

  typedef struct packed {
    logic      clr_step;
    logic      req_load;
    logic      scan_start;
    logic      scan_step;
    logic      look_read;
    logic      res_load;
    res_kind_e res_kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic quick;
    logic is_alloc;
    logic found;
    logic clr_last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* src/spba_if.sv */
`default_nettype none
interface spba_req_if import spba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] page_no;

  modport source (output valid, output req_type, output page_no, input ready);
  modport sink   (input valid, input req_type, input page_no, output ready);
endinterface

interface spba_res_if import spba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] page_out;
  logic             page_was_free;
  logic [CNT_W-1:0] free_pages;

  modport source (output valid, output status, output page_out, output page_was_free,
                  output free_pages, input ready);
  modport sink   (input valid, input status, input page_out, input page_was_free,
                  input free_pages, output ready);
endinterface

interface spba_cfg_if import spba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] page_count;

  modport source (output valid, output page_count, input ready);
  modport sink   (input valid, input page_count, output ready);
endinterface
`default_nettype wire

/* src/spba_ram.sv */
`default_nettype none
module spba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/spba_ctrl.sv */
`default_nettype none
module spba_ctrl import spba_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  input  wire dp_sts_t  sts_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || res_ready_i;
  // no request is taken in the cycle a page count write lands
  assign req_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, res_kind: RES_QUICK};
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_START;
        end
      end
      S_START: begin
        if (sts_i.quick) begin
          if (slot_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_QUICK;
            state_d        = S_IDLE;
          end
        end else if (sts_i.is_alloc) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.look_read = 1'b1;
          state_d         = S_LOOK;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.found && slot_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_ALLOC;
          state_d        = S_IDLE;
        end
      end
      S_LOOK: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_LOOK;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a page count write restarts the clearing sweep
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* src/spba_dp.sv */
`default_nettype none
module spba_dp import spba_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctl_cmd_t         cmd_i,
  output dp_sts_t               sts_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_page_count_i,
  input  wire logic [REQ_W-1:0] req_type_i,
  input  wire logic [IDX_W-1:0] page_no_i,
  output logic      [ST_W-1:0]  status_o,
  output logic      [IDX_W-1:0] page_out_o,
  output logic                  page_was_free_o,
  output logic      [CNT_W-1:0] free_pages_o
);

  localparam int MapWords = (MAX_PAGES + 31) / 32;
  localparam int WAW      = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int PageW    = WAW + 5;
  localparam int PcMaxI   = (MAX_PAGES > 8191) ? 8191 : MAX_PAGES;
  localparam int PcRstI   = (MAX_PAGES < 4096) ? MAX_PAGES : 4096;
  localparam logic [CNT_W-1:0] PcMax   = CNT_W'(PcMaxI);
  localparam logic [CNT_W-1:0] PcReset = CNT_W'(PcRstI);
  localparam logic [WAW-1:0]   LastWord = WAW'(MapWords - 1);

  logic [CNT_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [WAW-1:0]   addr_q, addr_d;
  logic [REQ_W-1:0] rtype_q;
  logic [IDX_W-1:0] ridx_q;
  logic [ST_W-1:0]  status_q, status_d;
  logic [IDX_W-1:0] page_q, page_d;
  logic             was_q, was_d;
  logic [CNT_W-1:0] fp_q;

  logic             ram_we, ram_re;
  logic [WAW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, rdata;

  logic [31:0]      idx_word32, addr32, pcw32, vmask, free_bits;
  logic [WAW-1:0]   look_addr;
  logic [4:0]       pos;
  logic             found, busy, is_alloc;
  logic [PageW-1:0] alloc_page;
  logic [31:0]      alloc_page32;
  logic [31:0]      bit_sel;

  spba_ram #(.WIDTH(32), .DEPTH(MapWords)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign is_alloc   = (rtype_q == REQ_ALLOC);
  assign idx_word32 = 32'(ridx_q[IDX_W-1:5]);
  assign look_addr  = idx_word32[WAW-1:0];

  // bits of the word under scan that lie inside the page count
  assign addr32 = 32'(addr_q);
  assign pcw32  = 32'(pc_q[CNT_W-1:5]);
  always_comb begin
    if (addr32 < pcw32) begin
      vmask = '1;
    end else if (addr32 == pcw32) begin
      vmask = (32'd1 << pc_q[4:0]) - 32'd1;
    end else begin
      vmask = '0;
    end
  end
  assign free_bits = ~rdata & vmask;
  assign found     = |free_bits;

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int b = 31; b >= 0; b--) begin
      if (free_bits[b]) pos = 5'(b);
    end
  end

  assign alloc_page   = {addr_q, pos};
  assign alloc_page32 = 32'(alloc_page);
  assign busy         = rdata[ridx_q[4:0]];
  assign bit_sel      = 32'd1 << (is_alloc ? pos : ridx_q[4:0]);

  assign sts_o.quick    = is_alloc ? (free_q == '0) : ({1'b0, ridx_q} >= pc_q);
  assign sts_o.is_alloc = is_alloc;
  assign sts_o.found    = found;
  assign sts_o.clr_last = (addr_q == LastWord);

  // result, counter and map write
  always_comb begin
    status_d  = ST_OK;
    page_d    = ridx_q;
    was_d     = 1'b0;
    free_d    = free_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    case (cmd_i.res_kind)
      RES_QUICK: begin
        if (is_alloc) begin
          status_d = ST_FULL;
          page_d   = '0;
        end else begin
          status_d = ST_RANGE;
        end
      end
      RES_ALLOC: begin
        page_d    = alloc_page32[IDX_W-1:0];
        was_d     = 1'b1;
        ram_we    = cmd_i.res_load;
        ram_wdata = rdata | bit_sel;
        if (free_q != '0) free_d = free_q - 1'b1;
      end
      RES_LOOK: begin
        was_d     = !busy;
        ram_waddr = look_addr;
        if (rtype_q == REQ_FREE) begin
          if (!busy) begin
            status_d = ST_ALREADY_FREE;
          end else begin
            ram_we    = cmd_i.res_load;
            ram_wdata = rdata & ~bit_sel;
            if (free_q < pc_q) free_d = free_q + 1'b1;
          end
        end else if (rtype_q == REQ_OCCUPY) begin
          if (busy) begin
            status_d = ST_ALREADY_OCC;
          end else begin
            ram_we    = cmd_i.res_load;
            ram_wdata = rdata | bit_sel;
            if (free_q != '0) free_d = free_q - 1'b1;
          end
        end
      end
      default: status_d = ST_OK;
    endcase
    if (!cmd_i.res_load) free_d = free_q;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q;
      ram_wdata = '0;
    end
  end

  // read port: scan issues the next word while checking the current one
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd_i.scan_start) begin
      ram_re = 1'b1;
    end else if (cmd_i.scan_step && !found) begin
      ram_re    = 1'b1;
      ram_raddr = addr_q + 1'b1;
    end else if (cmd_i.look_read) begin
      ram_re    = 1'b1;
      ram_raddr = look_addr;
    end
  end

  always_comb begin
    addr_d = addr_q;
    pc_d   = pc_q;
    if (cfg_we_i) begin
      pc_d   = (cfg_page_count_i > PcMax) ? PcMax : cfg_page_count_i;
      addr_d = '0;
    end else if (cmd_i.clr_step || (cmd_i.scan_step && !found)) begin
      addr_d = addr_q + 1'b1;
    end else if (cmd_i.scan_start) begin
      addr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PcReset;
      free_q <= PcReset;
      addr_q <= '0;
    end else begin
      pc_q   <= pc_d;
      addr_q <= addr_d;
      free_q <= cfg_we_i ? pc_d : free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      rtype_q <= req_type_i;
      ridx_q  <= page_no_i;
    end
    if (cmd_i.res_load) begin
      status_q <= status_d;
      page_q   <= page_d;
      was_q    <= was_d;
      fp_q     <= free_d;
    end
  end

  assign status_o        = status_q;
  assign page_out_o      = page_q;
  assign page_was_free_o = was_q;
  assign free_pages_o    = fp_q;

endmodule
`default_nettype wire

/* src/swap_page_bitmap_allocator.sv */
// channel  dir  payload                                       transfer
// req_i    in   req_type, page_no                             valid & ready
// res_o    out  status, page_out, page_was_free, free_pages   valid & ready
// cfg_i    in   page_count (always ready)                     valid & ready
//
// allocate: scans the map word by word from word 0 up to the first free page in range;
// the map is a 32-bit occupancy ram with a single read port
// free, occupy, query: one map word read; disk full or out of range: no map read
// after reset and after each page count write a clearing sweep zeroes every map
// word; no request is taken during it
// a result held on res_o lets one more request in, which then waits before its result loads
`default_nettype none
module swap_page_bitmap_allocator import spba_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spba_req_if.sink   req_i,
  spba_res_if.source res_o,
  spba_cfg_if.sink   cfg_i
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  spba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spba_dp #(.MAX_PAGES(MAX_PAGES)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we),
    .cfg_page_count_i (cfg_i.page_count),
    .req_type_i       (req_i.req_type),
    .page_no_i        (req_i.page_no),
    .status_o         (res_o.status),
    .page_out_o       (res_o.page_out),
    .page_was_free_o  (res_o.page_was_free),
    .free_pages_o     (res_o.free_pages)
  );

endmodule
`default_nettype wire
